[rtl/dqr_pkg.sv]
// Shared constants, codes and types for the deque with remove-by-value.
package dqr_pkg;

  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int REQ_W  = 3;
  localparam int CNT_OUT_W = 5;

  localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

  // request codes; unused codes behave as query
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd3;
  localparam logic [REQ_W-1:0] REQ_QUERY      = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_RD_F,
    ST_RD_B,
    ST_CAP_B,
    ST_DONE
  } state_t;

  // operands for the shared slot/compare unit
  typedef struct packed {
    logic [PTR_W-1:0]  first;
    logic [PTR_W-1:0]  pos;
    logic [DATA_W-1:0] lhs;
    logic [DATA_W-1:0] rhs;
  } unit_in_t;

  typedef struct packed {
    logic [PTR_W-1:0] slot;
    logic             eq;
  } unit_out_t;

endpackage

[rtl/dqr_ram.sv]
// Generic simple dual-port RAM with registered read.
module dqr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/dqr_unit.sv]
// Shared unit: circular slot address (first + pos mod DEPTH) and word compare.
module dqr_unit import dqr_pkg::*; (
  input  unit_in_t  u_in,
  output unit_out_t u_out
);

  localparam logic [PTR_W:0] DEPTH_W = (PTR_W + 1)'(DEPTH);

  logic [PTR_W:0] sum;

  always_comb begin
    sum = {1'b0, u_in.first} + {1'b0, u_in.pos};
    if (sum >= DEPTH_W) begin
      sum = sum - DEPTH_W;
    end
    u_out.slot = sum[PTR_W-1:0];
    u_out.eq   = (u_in.lhs == u_in.rhs);
  end

endmodule

[rtl/deque_with_remove_by_value.sv]
// Top level: bounded deque with remove-by-value, sequenced over one RAM port pair.
//
//  channel | dir | tdata (low bit up)                                   | tuser
//  in_     | in  | item_value[31:0]                                     | req_type[2:0]
//  out_    | out | front[31:0] back[63:32] count[68:64] empty[69]       | -
//          |     | matched[70] dropped[71]                              |
//
// Push, clear, query run exec, front read, back read, capture, result load, idle;
// an empty store skips back read and capture. The result shows on the return to idle.
// Remove adds a read and a compare state per entry scanned, a read and a write state
// per later entry moved and a read on a hit; the single registered-read port sets this.
// in_tready is high only in idle; a finished word waits in the output register
// while the next word is accepted. Synchronous active-low reset empties the store.
module deque_with_remove_by_value import dqr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // item_value[31:0]
  input  logic [2:0]  in_tuser,   // req_type[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata   // front, back, count[4:0], empty, matched, dropped
);

  state_t state_r, state_nxt;
  logic [PTR_W-1:0]  first_r, first_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [PTR_W-1:0]  pos_r, pos_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] front_r, front_nxt;
  logic [DATA_W-1:0] back_r, back_nxt;
  logic              matched_r, matched_nxt;
  logic              dropped_r, dropped_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [71:0]       out_data_r, out_data_nxt;

  unit_in_t          u_in;
  unit_out_t         u_out;
  logic              ram_we;
  logic [DATA_W-1:0] ram_wdata;
  logic [DATA_W-1:0] ram_rdata;
  logic [CNT_W-1:0]  pos_inc;
  logic              full;

  dqr_unit u_unit (
    .u_in  (u_in),
    .u_out (u_out)
  );

  dqr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (u_out.slot),
    .wdata (ram_wdata),
    .raddr (u_out.slot),
    .rdata (ram_rdata)
  );

  assign pos_inc    = CNT_W'(pos_r) + 1'b1;
  assign full       = (count_r >= CNT_W'(DEPTH));
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    req_nxt       = req_r;
    val_nxt       = val_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    matched_nxt   = matched_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    u_in.first    = first_r;
    u_in.pos      = pos_r;
    u_in.lhs      = ram_rdata;
    u_in.rhs      = val_r;
    ram_we        = 1'b0;
    ram_wdata     = val_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          req_nxt     = in_tuser;
          val_nxt     = in_tdata;
          matched_nxt = 1'b0;
          dropped_nxt = 1'b0;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_RD_F;
        unique case (req_r)
          REQ_PUSH_BACK: begin
            if (full) begin
              dropped_nxt = 1'b1;
            end else begin
              u_in.pos  = count_r[PTR_W-1:0];
              ram_we    = 1'b1;
              count_nxt = count_r + 1'b1;
            end
          end
          REQ_PUSH_FRONT: begin
            if (full) begin
              dropped_nxt = 1'b1;
            end else begin
              // first + DEPTH-1 wraps to first - 1
              u_in.pos  = PTR_W'(DEPTH - 1);
              ram_we    = 1'b1;
              first_nxt = u_out.slot;
              count_nxt = count_r + 1'b1;
            end
          end
          REQ_REMOVE: begin
            pos_nxt = '0;
            if (count_r != '0) begin
              state_nxt = ST_SCAN_RD;
            end
          end
          REQ_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
            // query and unused codes leave the store alone
          end
        endcase
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (u_out.eq) begin
          state_nxt = ST_SH_RD;
        end else if (pos_inc < count_r) begin
          pos_nxt   = pos_inc[PTR_W-1:0];
          state_nxt = ST_SCAN_RD;
        end else begin
          state_nxt = ST_RD_F;
        end
      end
      ST_SH_RD: begin
        if (pos_inc < count_r) begin
          u_in.pos  = pos_inc[PTR_W-1:0];
          state_nxt = ST_SH_WR;
        end else begin
          count_nxt   = count_r - 1'b1;
          matched_nxt = 1'b1;
          state_nxt   = ST_RD_F;
        end
      end
      ST_SH_WR: begin
        // move the later word one place toward the front
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        pos_nxt   = pos_inc[PTR_W-1:0];
        state_nxt = ST_SH_RD;
      end
      ST_RD_F: begin
        if (count_r == '0) begin
          front_nxt = EMPTY_VALUE;
          back_nxt  = EMPTY_VALUE;
          state_nxt = ST_DONE;
        end else begin
          u_in.pos  = '0;
          state_nxt = ST_RD_B;
        end
      end
      ST_RD_B: begin
        front_nxt = ram_rdata;
        u_in.pos  = PTR_W'(count_r - 1'b1);
        state_nxt = ST_CAP_B;
      end
      ST_CAP_B: begin
        back_nxt  = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {dropped_r, matched_r, (count_r == '0),
                           CNT_OUT_W'(count_r), back_r, front_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      first_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    req_r      <= req_nxt;
    val_r      <= val_nxt;
    front_r    <= front_nxt;
    back_r     <= back_nxt;
    matched_r  <= matched_nxt;
    dropped_r  <= dropped_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

[rtl/dqr_checker.sv]
// Port-level checker for the deque, bound to the top level.
module dqr_checker import dqr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  a_empty_view: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[69] |->
      out_tdata[68:64] == 5'd0 && out_tdata[31:0] == EMPTY_VALUE &&
      out_tdata[63:32] == EMPTY_VALUE)
    else $error("empty result with a count or values");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[70] && out_tdata[71]))
    else $error("matched and dropped together");

  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[71] |-> out_tdata[68:64] == CNT_OUT_W'(DEPTH))
    else $error("push dropped while not full");

endmodule

bind deque_with_remove_by_value dqr_checker u_dqr_checker (.*);
